>>> src/cgd_pkg.sv
// shared constants and types for the ctc greedy decoder
// no dependencies; compiled first

package cgd_pkg;

    localparam int MAX_CLASSES = 64;
    localparam int SCORE_BITS  = 16;
    localparam int CLASS_BITS  = $clog2(MAX_CLASSES);
    localparam int COUNT_BITS  = 7;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    typedef logic signed [SCORE_BITS-1:0] score_t;
    typedef logic [CLASS_BITS-1:0]        class_t;
    typedef logic [COUNT_BITS-1:0]        count_t;

    localparam count_t COUNT_RESET = count_t'(29);
    localparam count_t COUNT_MIN   = count_t'(2);
    localparam count_t COUNT_MAX   = count_t'(MAX_CLASSES);
    localparam class_t BLANK_CLASS = class_t'(0);

    // one completed frame handed from front to back
    typedef struct packed {
        class_t winner;
        logic   final_frame;
    } frame_t;

endpackage

>>> src/cgd_ifs.sv
// valid/ready channel interfaces for scores, results and configuration
// depends on cgd_pkg

interface cgd_score_if;
    logic               valid;
    logic               ready;
    cgd_pkg::score_t    score;
    logic               final_frame;

    modport source (output valid, output score, output final_frame, input ready);
    modport sink   (input valid, input score, input final_frame, output ready);
endinterface

interface cgd_result_if;
    logic               valid;
    logic               ready;
    cgd_pkg::class_t    label;
    logic               has_label;
    logic               sequence_done;

    modport source (output valid, output label, output has_label, output sequence_done,
                    input ready);
    modport sink   (input valid, input label, input has_label, input sequence_done,
                    output ready);
endinterface

interface cgd_cfg_if;
    logic               valid;
    logic               ready;
    cgd_pkg::count_t    data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> src/ctc_greedy_decoder.sv
// Streaming CTC greedy decoder. One class score is taken per clock cycle, class 0
// (blank) first and class_count scores (clamped to 2..64) to a frame; while the frame
// queue has room the score channel never stalls. The front keeps a running argmax
// (first class seeds it, ties keep the lower class) and hands each completed frame to a
// four-entry queue; the back drops blanks and repeats of the last emitted label and
// registers the result, so each frame passes through the queue and then the output
// register. A final frame always gives a result with sequence_done set and clears
// the repeat memory. Up to five completed frames, four in the queue and one in the
// output register, are absorbed while results are stalled before the score channel stalls.
// Write class_count only while the block is idle.
// depends on cgd_pkg, cgd_ifs, cgd_front, cgd_queue and cgd_back

module ctc_greedy_decoder (
    input  logic          clk,
    input  logic          rst_n,
    cgd_cfg_if.sink       cfg,
    cgd_score_if.sink     scores,
    cgd_result_if.source  results
);
    import cgd_pkg::*;

    logic   push;
    frame_t push_frame;
    logic   pop;
    logic   full;
    logic   empty;
    frame_t head;

    cgd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .scores     (scores),
        .cfg        (cfg),
        .queue_full (full),
        .push       (push),
        .push_frame (push_frame)
    );

    cgd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_frame (push_frame),
        .pop        (pop),
        .full       (full),
        .empty      (empty),
        .head       (head)
    );

    cgd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .empty      (empty),
        .head       (head),
        .pop        (pop),
        .results    (results)
    );

endmodule

>>> src/cgd_front.sv
// front part: class counter, running argmax and class count register
// depends on cgd_pkg and cgd_ifs

module cgd_front (
    input  logic              clk,
    input  logic              rst_n,
    cgd_score_if.sink         scores,
    cgd_cfg_if.sink           cfg,
    input  logic              queue_full,
    output logic              push,
    output cgd_pkg::frame_t   push_frame
);
    import cgd_pkg::*;

    count_t class_count_reg;
    class_t class_pos_reg, class_pos_next;
    score_t best_score_reg, best_score_next;
    class_t best_class_reg, best_class_next;

    count_t eff_count;
    class_t last_class;
    logic   accept;
    logic   take;
    logic   complete;

    assign cfg.ready    = 1'b1;
    assign scores.ready = !queue_full;
    assign accept       = scores.valid && scores.ready;

    always_comb
    begin
        if (class_count_reg < COUNT_MIN)
            eff_count = COUNT_MIN;
        else if (class_count_reg > COUNT_MAX)
            eff_count = COUNT_MAX;
        else
            eff_count = class_count_reg;
        last_class = CLASS_BITS'(eff_count - count_t'(1));
    end

    // class 0 always seeds the max, later classes need a strictly larger score
    assign take     = (class_pos_reg == BLANK_CLASS) || (scores.score > best_score_reg);
    assign complete = (class_pos_reg >= last_class);

    always_comb
    begin
        class_pos_next  = class_pos_reg;
        best_score_next = best_score_reg;
        best_class_next = best_class_reg;
        push            = 1'b0;
        push_frame.winner      = take ? class_pos_reg : best_class_reg;
        push_frame.final_frame = scores.final_frame;
        if (accept)
        begin
            if (take)
            begin
                best_score_next = scores.score;
                best_class_next = class_pos_reg;
            end
            if (complete)
            begin
                class_pos_next = BLANK_CLASS;
                push           = 1'b1;
            end
            else
            begin
                class_pos_next = class_pos_reg + class_t'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            class_count_reg <= COUNT_RESET;
            class_pos_reg   <= '0;
            best_score_reg  <= '0;
            best_class_reg  <= '0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
                class_count_reg <= cfg.data;
            class_pos_reg  <= class_pos_next;
            best_score_reg <= best_score_next;
            best_class_reg <= best_class_next;
        end
    end

endmodule

>>> src/cgd_queue.sv
// short queue of completed frames between front and back
// depends on cgd_pkg

module cgd_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  cgd_pkg::frame_t   push_frame,
    input  logic              pop,
    output logic              full,
    output logic              empty,
    output cgd_pkg::frame_t   head
);
    import cgd_pkg::*;

    frame_t                 slots_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_BITS-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_BITS-1:0]   count_reg, count_next;

    assign full  = (count_reg == QCNT_BITS'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = slots_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = wr_ptr_reg + QPTR_BITS'(1);
        if (pop)
            rd_ptr_next = rd_ptr_reg + QPTR_BITS'(1);
        if (push && !pop)
            count_next = count_reg + QCNT_BITS'(1);
        else if (pop && !push)
            count_next = count_reg - QCNT_BITS'(1);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slots_reg[wr_ptr_reg] <= push_frame;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

>>> src/cgd_back.sv
// back part: duplicate and blank suppression, output register
// depends on cgd_pkg and cgd_ifs

module cgd_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              empty,
    input  cgd_pkg::frame_t   head,
    output logic              pop,
    cgd_result_if.source      results
);
    import cgd_pkg::*;

    class_t last_emitted_reg, last_emitted_next;
    logic   out_valid_reg, out_valid_next;
    class_t label_reg, label_next;
    logic   has_label_reg, has_label_next;
    logic   done_reg, done_next;
    logic   emit;

    assign results.valid         = out_valid_reg;
    assign results.label         = label_reg;
    assign results.has_label     = has_label_reg;
    assign results.sequence_done = done_reg;

    // a frame leaves the queue whenever the output slot is free or being drained
    assign pop  = !empty && (!out_valid_reg || results.ready);
    assign emit = (head.winner != BLANK_CLASS) && (head.winner != last_emitted_reg);

    always_comb
    begin
        last_emitted_next = last_emitted_reg;
        out_valid_next    = out_valid_reg && !results.ready;
        label_next        = label_reg;
        has_label_next    = has_label_reg;
        done_next         = done_reg;
        if (pop)
        begin
            if (emit)
                last_emitted_next = head.winner;
            if (head.final_frame)
                last_emitted_next = BLANK_CLASS;
            if (emit || head.final_frame)
            begin
                out_valid_next = 1'b1;
                label_next     = emit ? head.winner : BLANK_CLASS;
                has_label_next = emit;
                done_next      = head.final_frame;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_emitted_reg <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            last_emitted_reg <= last_emitted_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        label_reg     <= label_next;
        has_label_reg <= has_label_next;
        done_reg      <= done_next;
    end

endmodule
